FILE: hw/rtl/afc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_pkg: shared types and constants of the autoranging frequency counter
// Field widths, opcodes, register indexes, state encodings and small helpers.
// ============================================================================
package afc_pkg;

  // Field and state widths
  localparam int unsigned CntW    = 24;
  localparam int unsigned OvfW    = 8;
  localparam int unsigned AmtW    = 32;
  localparam int unsigned GmW     = 14;
  localparam int unsigned RefW    = 37;
  localparam int unsigned SumW    = 48;
  localparam int unsigned FreqW   = 47;
  localparam int unsigned DutyW   = 14;
  localparam int unsigned TallyW  = 16;
  localparam int unsigned EmptyW  = 5;
  localparam int unsigned HoldW   = 2;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GmulW   = AmtW + GmW;
  localparam int unsigned FmulW   = RefW + TallyW;
  localparam int unsigned DmulW   = SumW + DutyW;
  localparam int unsigned DivW    = 64;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // Constants
  localparam logic [CntW-1:0]   CntWrap      = 24'hffffff;
  localparam logic [SumW-1:0]   JumpLimit    = 48'd10000;
  localparam logic [DutyW-1:0]  DutyFull     = 14'd10000;
  localparam logic [EmptyW-1:0] EmptyTicks   = 5'd16;
  localparam logic [HoldW-1:0]  BlockResults = 2'd3;
  localparam logic [FreqW-1:0]  FreqMax      = '1;
  localparam logic [TallyW-1:0] TallyMax     = '1;

  // Reset values of the configuration registers
  localparam logic [GmW-1:0]         GateMultRst = 14'd1000;
  localparam logic [RefW-1:0]        RefFreqRst  = 37'd100000000000;
  localparam logic signed [SumW-1:0] SwLowRst    = 48'sd950000;
  localparam logic [FreqW-1:0]       SwHighRst   = 47'd1050000;

  typedef enum logic [1:0] {
    OP_GATE   = 2'd0,
    OP_PERIOD = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GATE_MULT = 2'd0,
    CFG_REF_FREQ  = 2'd1,
    CFG_SW_LOW    = 2'd2,
    CFG_SW_HIGH   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_GUPD,
    S_TMUL,
    S_FDIV,
    S_FWAIT,
    S_DDIV,
    S_DWAIT,
    S_POST
  } back_state_e;

  // Classified item: amount is the extended gate count for a gate capture,
  // the overflow extension for a tick, and the period for a period capture.
  typedef struct packed {
    opcode_e             kind;
    logic [AmtW-1:0]     amount;
    logic [CntW-1:0]     width;
    logic                ovf_nz;
  } item_t;

  typedef struct packed {
    logic [GmW-1:0]         gate_mult;
    logic [RefW-1:0]        ref_freq;
    logic signed [SumW-1:0] switch_low;
    logic [FreqW-1:0]       switch_high;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [SumW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  // Add two accumulator values, clamp at full scale
  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

FILE: hw/rtl/afc_if.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_if: capture and result channels
// Valid/ready channels carrying one capture beat in and one result beat out.
// ============================================================================
interface afc_in_if import afc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CntW-1:0]   capture_count;
  logic [CntW-1:0]   capture_width;
  logic [OvfW-1:0]   overflow_count;

  modport source(output valid, opcode, capture_count, capture_width, overflow_count,
                 input ready);
  modport sink(input valid, opcode, capture_count, capture_width, overflow_count,
               output ready);
endinterface

interface afc_out_if import afc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FreqW-1:0]  frequency;
  logic [DutyW-1:0]  duty;
  logic              duty_valid;
  logic              gated_mode;
  logic              mode_switched;

  modport source(output valid, frequency, duty, duty_valid, gated_mode, mode_switched,
                 input ready);
  modport sink(input valid, frequency, duty, duty_valid, gated_mode, mode_switched,
               output ready);
endinterface

FILE: hw/rtl/afc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_front: capture intake and classification
// Decodes each capture beat, extends counts by overflows and queues all but the unused opcode.
// ============================================================================
module afc_front import afc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  afc_in_if.sink      in_i,
  output item_t       item_o,
  output logic        item_valid_o,
  input  logic        item_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        accept, push;
  logic [AmtW-1:0] ext_ovf;
  item_t       item_new;

  // Classify the incoming beat
  assign ext_ovf = AmtW'(in_i.overflow_count) * AmtW'(CntWrap);

  always_comb begin
    item_new.kind   = opcode_e'(in_i.opcode);
    item_new.width  = in_i.capture_width;
    item_new.ovf_nz = (in_i.overflow_count != '0);
    case (opcode_e'(in_i.opcode))
      OP_GATE: item_new.amount = AmtW'(in_i.capture_count) + ext_ovf;
      OP_TICK: item_new.amount = ext_ovf;
      default: item_new.amount = AmtW'(in_i.capture_count);
    endcase
  end

  // Drop the unused opcode here; everything else goes to the queue
  assign in_i.ready = (count_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && (opcode_e'(in_i.opcode) != OP_NONE);

  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !item_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && item_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

FILE: hw/rtl/afc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_div: radix-2 restoring divider
// Divides a 64-bit dividend by a 48-bit divisor, one quotient bit a cycle.
// ============================================================================
module afc_div import afc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SumW:0]        rem_q, rem_d;
  logic [DivW-1:0]      quo_q, quo_d;
  logic [SumW-1:0]      dvs_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 done_q;
  logic [SumW:0]        shifted;
  logic                 fits;

  // One restoring step
  assign shifted = {rem_q[SumW-1:0], quo_q[DivW-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    rem_d = fits ? (shifted - {1'b0, dvs_q}) : shifted;
    quo_d = {quo_q[DivW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DivCntW'(1));
      if (req_i.start) begin
        cnt_q <= DivCntW'(DivW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - DivCntW'(1);
      end
    end
  end

  // Load operands, then shift
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: hw/rtl/afc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_back: measurement engine
// Runs gated and reciprocal updates, range switching and the result register.
// ============================================================================
module afc_back import afc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       item_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  afc_out_if.source   res_o
);

  back_state_e        state_q, state_d;
  item_t              cur_q, cur_d;
  logic               mode_q, mode_d;
  logic [FreqW-1:0]   freq_q, freq_d;
  logic [SumW-1:0]    psum_q, psum_d;
  logic [SumW-1:0]    wsum_q, wsum_d;
  logic [TallyW-1:0]  tally_q, tally_d;
  logic [EmptyW-1:0]  empty_q, empty_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic [DivW-1:0]    prod_q, prod_d;
  logic [FreqW-1:0]   rfreq_q, rfreq_d;
  logic [DutyW-1:0]   rduty_q, rduty_d;
  logic               rdval_q, rdval_d;

  logic               out_valid_q, out_valid_d;
  logic [FreqW-1:0]   out_freq_q, out_freq_d;
  logic [DutyW-1:0]   out_duty_q, out_duty_d;
  logic               out_dval_q, out_dval_d;
  logic               out_gated_q, out_gated_d;
  logic               out_sw_q, out_sw_d;

  logic [GmulW-1:0]   gmul;
  logic [FmulW-1:0]   fmul;
  logic [DmulW-1:0]   dmul;
  logic [SumW-1:0]    sample, fcur, diff, blend, gnew48;
  logic [FreqW-1:0]   gnew, fquo;
  logic [DutyW-1:0]   dquo;
  logic [HoldW-1:0]   hold_dec;
  logic               do_switch;

  // Multipliers, each feeding a register
  assign gmul = GmulW'(cur_q.amount) * GmulW'(cfg_i.gate_mult);
  assign fmul = FmulW'(cfg_i.ref_freq) * FmulW'(tally_q);
  assign dmul = DmulW'(wsum_q) * DmulW'(DutyFull);

  // Gated update: jump to the new sample or blend it in by one eighth
  assign sample = SumW'(prod_q[GmulW-1:0]);
  assign fcur   = SumW'(freq_q);
  assign diff   = (fcur > sample) ? (fcur - sample) : (sample - fcur);
  assign blend  = fcur - (fcur >> 3) + (sample >> 3);
  assign gnew48 = (diff > JumpLimit) ? sample : blend;
  assign gnew   = gnew48[SumW-1] ? FreqMax : gnew48[FreqW-1:0];

  // Clamp divider quotients
  assign fquo = (div_rsp_i.quotient[DivW-1:FreqW] != '0) ? FreqMax
                                                         : div_rsp_i.quotient[FreqW-1:0];
  assign dquo = (div_rsp_i.quotient > DivW'(DutyFull)) ? DutyFull
                                                       : div_rsp_i.quotient[DutyW-1:0];

  // Range switch with hysteresis and holdoff
  assign hold_dec  = (hold_q != '0) ? (hold_q - HoldW'(1)) : hold_q;
  assign do_switch = (hold_dec == '0) &&
                     (mode_q ? ($signed({1'b0, freq_q}) < $signed(cfg_i.switch_low))
                             : (freq_q > cfg_i.switch_high));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    mode_d      = mode_q;
    freq_d      = freq_q;
    psum_d      = psum_q;
    wsum_d      = wsum_q;
    tally_d     = tally_q;
    empty_d     = empty_q;
    hold_d      = hold_q;
    prod_d      = prod_q;
    rfreq_d     = rfreq_q;
    rduty_d     = rduty_q;
    rdval_d     = rdval_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_freq_d  = out_freq_q;
    out_duty_d  = out_duty_q;
    out_dval_d  = out_dval_q;
    out_gated_d = out_gated_q;
    out_sw_d    = out_sw_q;
    item_pop_o  = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = prod_q;
    div_req_o.divisor  = psum_q;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          state_d    = S_EXEC;
        end
      end

      // Dispatch on opcode and mode; items for the other mode are dropped
      S_EXEC: begin
        state_d = S_IDLE;
        if (mode_q && (cur_q.kind == OP_GATE)) begin
          prod_d  = DivW'(gmul);
          state_d = S_GUPD;
        end else if (!mode_q && (cur_q.kind == OP_PERIOD)) begin
          psum_d  = sat_add(psum_q, SumW'(cur_q.amount));
          wsum_d  = sat_add(wsum_q, SumW'(cur_q.width));
          empty_d = EmptyTicks;
          if (tally_q != TallyMax) begin
            tally_d = tally_q + TallyW'(1);
          end
        end else if (!mode_q && (cur_q.kind == OP_TICK)) begin
          if (((tally_q == '0) || (psum_q == '0)) && (empty_q != '0)) begin
            empty_d = empty_q - EmptyW'(1);
          end else begin
            psum_d  = sat_add(psum_q, SumW'(cur_q.amount));
            state_d = S_TMUL;
          end
        end
      end

      S_GUPD: begin
        freq_d  = gnew;
        rfreq_d = gnew;
        rduty_d = '0;
        rdval_d = 1'b0;
        state_d = S_POST;
      end

      // Zero divisor yields zero frequency
      S_TMUL: begin
        if (psum_q == '0) begin
          freq_d  = '0;
          rfreq_d = '0;
          rduty_d = '0;
          rdval_d = 1'b0;
          state_d = S_POST;
        end else begin
          prod_d  = DivW'(fmul);
          state_d = S_FDIV;
        end
      end

      S_FDIV: begin
        div_req_o.start = 1'b1;
        state_d         = S_FWAIT;
      end

      S_FWAIT: begin
        if (div_rsp_i.done) begin
          freq_d  = fquo;
          rfreq_d = fquo;
          rduty_d = '0;
          rdval_d = 1'b0;
          if (cur_q.ovf_nz) begin
            state_d = S_POST;
          end else begin
            prod_d  = DivW'(dmul);
            state_d = S_DDIV;
          end
        end
      end

      S_DDIV: begin
        div_req_o.start = 1'b1;
        state_d         = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_rsp_i.done) begin
          rduty_d = dquo;
          rdval_d = 1'b1;
          state_d = S_POST;
        end
      end

      // Publish the beat, then apply range switching
      S_POST: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_freq_d  = rfreq_q;
          out_duty_d  = rduty_q;
          out_dval_d  = rdval_q;
          out_gated_d = mode_q ^ do_switch;
          out_sw_d    = do_switch;
          hold_d      = hold_dec;
          if (!mode_q) begin
            psum_d  = '0;
            wsum_d  = '0;
            tally_d = '0;
          end
          if (do_switch) begin
            mode_d  = !mode_q;
            freq_d  = '0;
            psum_d  = '0;
            wsum_d  = '0;
            tally_d = '0;
            hold_d  = BlockResults;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b1;
      freq_q      <= '0;
      psum_q      <= '0;
      wsum_q      <= '0;
      tally_q     <= '0;
      empty_q     <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      freq_q      <= freq_d;
      psum_q      <= psum_d;
      wsum_q      <= wsum_d;
      tally_q     <= tally_d;
      empty_q     <= empty_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    prod_q      <= prod_d;
    rfreq_q     <= rfreq_d;
    rduty_q     <= rduty_d;
    rdval_q     <= rdval_d;
    out_freq_q  <= out_freq_d;
    out_duty_q  <= out_duty_d;
    out_dval_q  <= out_dval_d;
    out_gated_q <= out_gated_d;
    out_sw_q    <= out_sw_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.frequency     = out_freq_q;
  assign res_o.duty          = out_duty_q;
  assign res_o.duty_valid    = out_dval_q;
  assign res_o.gated_mode    = out_gated_q;
  assign res_o.mode_switched = out_sw_q;

endmodule

FILE: hw/rtl/autoranging_frequency_counter_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// autoranging_frequency_counter_unit: frequency counter post-processing
// Turns raw gate and period captures into frequency and duty with autoranging.
// ============================================================================
// Captures enter a two-beat queue and are executed one at a time by the
// measurement engine. A gated capture passes the execute, update and post
// states; a direct period capture only accumulates in the execute state. A
// direct gate tick that produces a result passes the frequency and then the
// duty quotient through the shared radix-2 divider, with the multiplies and
// the result register around them; overflows suppress the duty. Ticks held
// off by an empty gate, and captures that do not belong to the current mode,
// give no result. A result waiting in the output register does not stop new
// captures from queuing. Configuration writes take effect at once and are
// meant for idle periods.
module autoranging_frequency_counter_unit import afc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  afc_in_if.sink               in_i,
  afc_out_if.source            res_o
);

  cfg_t      cfg_q;
  item_t     item;
  logic      item_valid, item_pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_mult   <= GateMultRst;
      cfg_q.ref_freq    <= RefFreqRst;
      cfg_q.switch_low  <= SwLowRst;
      cfg_q.switch_high <= SwHighRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GATE_MULT: cfg_q.gate_mult   <= cfg_wdata_i[GmW-1:0];
        CFG_REF_FREQ:  cfg_q.ref_freq    <= cfg_wdata_i[RefW-1:0];
        CFG_SW_LOW:    cfg_q.switch_low  <= $signed(cfg_wdata_i[SumW-1:0]);
        CFG_SW_HIGH:   cfg_q.switch_high <= cfg_wdata_i[FreqW-1:0];
        default:       cfg_q.gate_mult   <= cfg_q.gate_mult;
      endcase
    end
  end

  afc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  afc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  afc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_o        (res_o)
  );

endmodule

FILE: hw/rtl/afc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_checker: result channel checks
// Port-level checks of the result beats, bound to the top level.
// ============================================================================
module afc_checker import afc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [FreqW-1:0]  res_frequency_i,
  input logic [DutyW-1:0]  res_duty_i,
  input logic              res_duty_valid_i,
  input logic              res_gated_mode_i,
  input logic              res_mode_switched_i
);

  // Hold a stalled beat
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_frequency_i) && $stable(res_duty_i))
    else $error("result beat changed while stalled");

  // Duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_duty_i <= DutyFull))
    else $error("duty above full scale");

  // Duty is zero unless flagged valid
  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_duty_valid_i |-> (res_duty_i == '0))
    else $error("duty nonzero without duty_valid");

  // Duty comes from direct mode, so gated after it means a switch happened
  a_duty_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_duty_valid_i && res_gated_mode_i |-> res_mode_switched_i)
    else $error("duty result in gated mode without a switch");

endmodule

bind autoranging_frequency_counter_unit afc_checker u_afc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .res_frequency_i     (res_o.frequency),
  .res_duty_i          (res_o.duty),
  .res_duty_valid_i    (res_o.duty_valid),
  .res_gated_mode_i    (res_o.gated_mode),
  .res_mode_switched_i (res_o.mode_switched)
);
